@@ rtl/core/lws_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_pkg
// Shared command codes and controller state type for the latency window
// statistics block.
// ----------------------------------------------------------------------------
package lws_pkg;

	localparam logic [1:0] CMD_ADD   = 2'd0;
	localparam logic [1:0] CMD_QUERY = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	localparam int OUT_W = 40;
	localparam int CNT_OUT_W = 11;
	localparam int PCT_W = 7;
	localparam int RANK_DIV = 100;

	// ceil(2^32 / 100); x * RANK_RECIP >> RANK_SHIFT == x / 100 for x < 2^30
	localparam logic [25:0] RANK_RECIP = 26'd42949673;
	localparam int RANK_SHIFT = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MEAN,
		ST_RANK,
		ST_READ,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic ins;
		logic clr;
	} cell_ctl_t;

endpackage

@@ rtl/core/lws_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_cell
// One slot of the sorted sample chain: takes its left neighbour's value or
// the new sample so that the chain stays in ascending order.
// ----------------------------------------------------------------------------
module lws_cell #(
	parameter int LB = 40
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  lws_pkg::cell_ctl_t   ctl,
	input  logic [LB-1:0]        sample,
	input  logic [LB-1:0]        left_val,
	input  logic                 left_vld,
	input  logic                 left_gt,
	output logic [LB-1:0]        val,
	output logic                 vld,
	output logic                 gt
);
	import lws_pkg::*;

	logic [LB-1:0] val_q;
	logic          vld_q;
	logic          take;

	assign gt   = vld_q && (val_q > sample);
	// strict compare keeps a new sample behind equal ones
	assign take = gt || (!vld_q && left_vld);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctl.clr) begin
			vld_q <= 1'b0;
		end else if (ctl.ins && take) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.ins && !ctl.clr && take) begin
			val_q <= left_gt ? left_val : sample;
		end
	end

	assign val = val_q;
	assign vld = vld_q;

endmodule

@@ rtl/core/lws_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lws_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lws_div #(
	parameter int DW = 50,
	parameter int VW = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);
	import lws_pkg::*;

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] q_q;
	logic [VW:0]   rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic          fit;

	assign trial = {rem_q[VW-1:0], q_q[DW-1]};
	assign fit   = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (run_q) begin
			rem_q <= fit ? (trial - {1'b0, dvs_q}) : trial;
			q_q   <= {q_q[DW-2:0], fit};
		end
	end

	assign done     = done_q;
	assign quotient = q_q;

endmodule

@@ rtl/core/latency_window_percentile_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// latency_window_percentile_stats
// Sorted window of latency samples with min, max, mean, count and
// nearest-rank percentile on query.
// ----------------------------------------------------------------------------
// Channel   Ports                                             Handshake
// request   command, latency_ns, percentile_pct              start & !busy
// result    lowest/highest/mean/percentile_latency,          valid, 1 cycle
//           sample_count, overflow
//
// Add and clear keep busy low, so the next request may follow at once.
// The sample is registered into the cell chain when the add is accepted.
// Query: busy through a serial mean division of SUM_W steps, rank by
// reciprocal multiply, index and cell read, or straight to the result for
// an empty window; result in the last state. Results cannot be held off.
// Reset clears all control state; sample cells need no clearing pass.
// ----------------------------------------------------------------------------
module latency_window_percentile_stats #(
	parameter int WINDOW_DEPTH = 1024,
	parameter int LATENCY_BITS = 40
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [39:0] latency_ns,
	input  logic [6:0]  percentile_pct,
	output logic        valid,
	output logic [39:0] lowest_latency,
	output logic [39:0] highest_latency,
	output logic [39:0] mean_latency,
	output logic [39:0] percentile_latency,
	output logic [10:0] sample_count,
	output logic        overflow
);
	import lws_pkg::*;

	localparam int LB      = LATENCY_BITS;
	localparam int D       = WINDOW_DEPTH;
	localparam int CNT_W   = $clog2(D + 1);
	localparam int IW      = $clog2(D);
	localparam int SUM_RAW = LB + CNT_W;
	localparam int SUM_W   = (SUM_RAW > 64) ? 64 : SUM_RAW;
	localparam int VW      = (CNT_W > PCT_W) ? CNT_W : PCT_W;
	localparam int PN_W    = PCT_W + CNT_W + 1;
	localparam int PR_W    = PN_W + 26;

	state_t state_q, state_d;

	logic [LB-1:0]    min_q, max_q, perc_q;
	logic [SUM_W-1:0] sum_q, mean_q;
	logic [PN_W-1:0]  pn_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [IW-1:0]    idx_q;

	logic             req;
	logic [LB-1:0]    sample;
	logic             full;
	cell_ctl_t        ctl;

	logic             div_go;
	logic [SUM_W-1:0] div_a;
	logic [VW-1:0]    div_b;
	logic             div_done;
	logic [SUM_W-1:0] div_q;

	logic [LB-1:0]    cell_val [D];
	logic             cell_vld [D];
	logic             cell_gt  [D];
	logic [PR_W-1:0]  rank_prod;
	logic [PN_W-1:0]  rank_c;
	logic [63:0]      mean_ext;

	function automatic logic [39:0] fit40(input logic [LB-1:0] x);
		logic [63:0] t;
		t = 64'(x);
		return t[39:0];
	endfunction

	assign req    = start && !busy;
	assign sample = LB'(64'(latency_ns));
	assign full   = cnt_q >= CNT_W'(D);
	assign ctl.ins = req && (command == CMD_ADD) && !full;
	assign ctl.clr = req && (command == CMD_CLEAR);

	genvar g;
	generate
		for (g = 0; g < D; g++) begin : g_cell
			if (g == 0) begin : g_first
				lws_cell #(.LB(LB)) u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(sample),
					.left_val(sample), .left_vld(1'b1), .left_gt(1'b0),
					.val(cell_val[g]), .vld(cell_vld[g]), .gt(cell_gt[g])
				);
			end else begin : g_rest
				lws_cell #(.LB(LB)) u_cell (
					.clk(clk), .arst_n(arst_n), .ctl(ctl), .sample(sample),
					.left_val(cell_val[g-1]), .left_vld(cell_vld[g-1]),
					.left_gt(cell_gt[g-1]),
					.val(cell_val[g]), .vld(cell_vld[g]), .gt(cell_gt[g])
				);
			end
		end
	endgenerate

	lws_div #(.DW(SUM_W), .VW(VW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go), .dividend(div_a),
		.divisor(div_b), .done(div_done), .quotient(div_q)
	);

	// rank = (p * n + 99) / 100 by reciprocal multiply
	assign rank_prod = PR_W'(pn_q) * PR_W'(RANK_RECIP);

	always_comb begin
		rank_c = PN_W'(rank_prod >> RANK_SHIFT);
		if (rank_c == '0) rank_c = PN_W'(1);
		if (rank_c > PN_W'(cnt_q)) rank_c = PN_W'(cnt_q);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (req && command == CMD_QUERY)
				state_d = (cnt_q == '0) ? ST_OUT : ST_MEAN;
			ST_MEAN: if (div_done) state_d = ST_RANK;
			ST_RANK: state_d = ST_READ;
			ST_READ: state_d = ST_OUT;
			ST_OUT:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy   = (state_q != ST_IDLE);
		valid  = (state_q == ST_OUT);
		div_go = 1'b0;
		div_a  = sum_q;
		div_b  = VW'(cnt_q);
		unique case (state_q)
			ST_IDLE: div_go = req && (command == CMD_QUERY) && (cnt_q != '0);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			min_q   <= '1;
			max_q   <= '0;
			sum_q   <= '0;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.clr) begin
				min_q <= '1;
				max_q <= '0;
				sum_q <= '0;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else if (req && command == CMD_ADD) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
					sum_q <= sum_q + SUM_W'(sample);
					if (sample < min_q) min_q <= sample;
					if (sample > max_q) max_q <= sample;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req && command == CMD_QUERY) begin
			pn_q   <= PN_W'(percentile_pct) * PN_W'(cnt_q) + PN_W'(RANK_DIV - 1);
			mean_q <= '0;
			perc_q <= '0;
		end
		if (state_q == ST_MEAN && div_done) mean_q <= div_q;
		if (state_q == ST_RANK) idx_q <= IW'(rank_c - PN_W'(1));
		if (state_q == ST_READ) perc_q <= cell_val[idx_q];
	end

	assign mean_ext = 64'(mean_q);

	assign lowest_latency     = fit40(min_q);
	assign highest_latency    = fit40(max_q);
	assign mean_latency       = mean_ext[39:0];
	assign percentile_latency = fit40(perc_q);
	assign sample_count       = CNT_OUT_W'(32'(cnt_q));
	assign overflow           = ovf_q;

endmodule
